@@ sv/swmf_pkg.sv @@
package swmf_pkg;

	// Fixed field widths
	localparam int SAMPLE_W = 16;
	localparam int SIZE_W   = 6;

	// Window size after reset
	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(20);

	// Controller to datapath commands
	typedef struct packed {
		logic capture;   // input beat taken: latch sample, read old entry
		logic update;    // write entry, update running total, start divide
		logic load_out;  // load output register
		logic clear;     // size write: clear window, position, flag, total
	} swmf_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic div_busy;
	} swmf_sts_t;

endpackage

@@ sv/sliding_window_mean_filter.sv @@
// Moving average over a configurable window of signed 16-bit samples.
// Each sample passes the update, divide and done steps before its result is registered;
// the divide runs on the one-bit-per-cycle divider over TW = 16 + clog2(WINDOW_MAX) bits.
// One sample is in work at a time; the next sample is taken while a result waits.
// Reset (arst_n low, async): window size 20, window store empty (reads as zero),
// write position, filled flag and running total zero, no result pending.
module sliding_window_mean_filter import swmf_pkg::*; #(
	parameter int WINDOW_MAX = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// sample channel
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic signed [SAMPLE_W-1:0] sample,
	// result channel
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [SAMPLE_W-1:0] mean,
	output logic                       window_full,
	// window size register write
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic        [SIZE_W-1:0]   window_size
);

	// Flow per sample beat:
	//   accept  : latch sample, read the old entry at the write position
	//             (entries not written since the last clear read as zero)
	//   update  : total += sample - old entry, write entry, advance and wrap
	//             the position; first wrap sets the filled flag; start divide
	//   divide  : |total| / size, one quotient bit per cycle, sign restored
	//             afterward so the mean truncates toward zero
	//   done    : load the output register once it is free, then go idle
	// A size write (only while idle) clears store valid bits, position,
	// flag and total together; the new size applies from the next sample.

	swmf_cmd_t cmd;
	swmf_sts_t sts;

	swmf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	swmf_datapath #(
		.WINDOW_MAX(WINDOW_MAX)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.sample      (sample),
		.window_size (window_size),
		.mean        (mean),
		.window_full (window_full)
	);

endmodule

@@ sv/swmf_div.sv @@
module swmf_div import swmf_pkg::*; #(
	parameter int TW = 21
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic signed [TW-1:0]       dividend,
	input  logic        [SIZE_W-1:0]   divisor,
	output logic                       busy,
	output logic signed [SAMPLE_W-1:0] quotient
);

	localparam int CW = $clog2(TW + 1);

	logic [CW-1:0]     cnt_q;
	logic              neg_q;
	logic [TW-1:0]     quo_q;
	logic [SIZE_W-1:0] rem_q;
	logic [SIZE_W-1:0] dvs_q;

	logic [SIZE_W:0]   rem_sh;
	logic [SIZE_W:0]   rem_nxt;
	logic              ge;
	logic [TW-1:0]     mag;
	logic [TW-1:0]     res;

	// restoring divide, one quotient bit per cycle, on the magnitude
	assign rem_sh  = {rem_q, quo_q[TW-1]};
	assign ge      = rem_sh >= {1'b0, dvs_q};
	assign rem_nxt = ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
	assign mag     = dividend[TW-1] ? (~dividend + 1'b1) : dividend;
	assign res     = neg_q ? (~quo_q + 1'b1) : quo_q;
	assign quotient = res[SAMPLE_W-1:0];
	assign busy    = (cnt_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			neg_q <= 1'b0;
		end else if (start) begin
			cnt_q <= CW'(TW);
			neg_q <= dividend[TW-1];
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= mag;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy) begin
			quo_q <= {quo_q[TW-2:0], ge};
			rem_q <= rem_nxt[SIZE_W-1:0];
		end
	end

endmodule

@@ sv/swmf_datapath.sv @@
module swmf_datapath import swmf_pkg::*; #(
	parameter int WINDOW_MAX = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  swmf_cmd_t                  cmd,
	output swmf_sts_t                  sts,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic        [SIZE_W-1:0]   window_size,
	output logic signed [SAMPLE_W-1:0] mean,
	output logic                       window_full
);

	localparam int PW      = $clog2(WINDOW_MAX);
	localparam int TW      = SAMPLE_W + PW;
	localparam int CMPW    = (PW > SIZE_W) ? PW : SIZE_W;
	localparam int SIZE_TOP = (1 << SIZE_W) - 1;
	localparam int EFF_MAX = (WINDOW_MAX < SIZE_TOP) ? WINDOW_MAX : SIZE_TOP;
	localparam logic [SIZE_W-1:0] EFF_MAX_V = SIZE_W'(EFF_MAX);

	logic        [SIZE_W-1:0]   size_q;
	logic        [PW-1:0]       pos_q;
	logic                       filled_q;
	logic signed [TW-1:0]       total_q;
	logic        [WINDOW_MAX-1:0] vld_q;

	logic signed [SAMPLE_W-1:0] mem [WINDOW_MAX];
	logic signed [SAMPLE_W-1:0] sample_q;
	logic signed [SAMPLE_W-1:0] rd_q;
	logic                       old_vld_q;
	logic        [PW-1:0]       addr_q;
	logic signed [SAMPLE_W-1:0] mean_q;
	logic                       full_q;

	logic        [SIZE_W-1:0]   eff;
	logic        [PW-1:0]       pos_eff;
	logic signed [SAMPLE_W-1:0] old;
	logic signed [TW-1:0]       total_nxt;
	logic        [CMPW:0]       pos_inc;
	logic                       wrap;
	logic                       div_busy;
	logic signed [SAMPLE_W-1:0] quotient;

	// size zero counts as one, sizes above the store saturate
	always_comb begin
		eff = size_q;
		if (size_q == '0) begin
			eff = SIZE_W'(1);
		end else if (size_q > EFF_MAX_V) begin
			eff = EFF_MAX_V;
		end
	end

	assign pos_eff   = (CMPW'(pos_q) >= CMPW'(eff)) ? '0 : pos_q;
	assign old       = old_vld_q ? rd_q : '0;
	assign total_nxt = total_q + TW'(sample_q) - TW'(old);
	assign pos_inc   = (CMPW + 1)'(addr_q) + 1'b1;
	assign wrap      = pos_inc >= (CMPW + 1)'(eff);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q   <= SIZE_RESET;
			pos_q    <= '0;
			filled_q <= 1'b0;
			total_q  <= '0;
			vld_q    <= '0;
		end else if (cmd.clear) begin
			size_q   <= window_size;
			pos_q    <= '0;
			filled_q <= 1'b0;
			total_q  <= '0;
			vld_q    <= '0;
		end else if (cmd.update) begin
			total_q       <= total_nxt;
			vld_q[addr_q] <= 1'b1;
			if (wrap) begin
				pos_q    <= '0;
				filled_q <= 1'b1;
			end else begin
				pos_q <= pos_inc[PW-1:0];
			end
		end
	end

	// window store, registered read
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			rd_q <= mem[pos_eff];
		end
		if (cmd.update) begin
			mem[addr_q] <= sample_q;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			sample_q  <= sample;
			addr_q    <= pos_eff;
			old_vld_q <= vld_q[pos_eff];
		end
		if (cmd.load_out) begin
			mean_q <= filled_q ? quotient : '0;
			full_q <= filled_q;
		end
	end

	swmf_div #(
		.TW(TW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.update),
		.dividend (total_nxt),
		.divisor  (eff),
		.busy     (div_busy),
		.quotient (quotient)
	);

	assign sts.div_busy = div_busy;
	assign mean         = mean_q;
	assign window_full  = full_q;

endmodule

@@ sv/swmf_ctrl.sv @@
module swmf_ctrl import swmf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	output logic      out_valid,
	input  logic      out_stall,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	output swmf_cmd_t cmd,
	input  swmf_sts_t sts
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   idle;
	logic   out_free;

	assign idle     = (state_q == ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	// size writes win over a sample in the same cycle
	assign cfg_ready   = idle;
	assign in_stall    = !idle || cfg_valid;
	assign out_valid   = out_valid_q;

	assign cmd.capture  = idle && in_valid && !cfg_valid;
	assign cmd.update   = (state_q == ST_UPDATE);
	assign cmd.load_out = (state_q == ST_DONE) && out_free;
	assign cmd.clear    = idle && cfg_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.capture) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (!sts.div_busy) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

@@ sv/swmf_checker.sv @@
module swmf_props import swmf_pkg::*; (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_stall,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic signed [SAMPLE_W-1:0] mean,
	input logic                       window_full
);

	// a held result beat keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(mean) && $stable(window_full))
		else $error("result beat changed while stalled");

	// mean is zero until the window has filled
	a_zero_unfilled: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !window_full |-> mean == '0)
		else $error("nonzero mean before window filled");

	// one sample at a time: busy right after a sample beat
	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("sample taken while previous one in work");

	// a new result only comes out of a busy cycle
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without work in progress");

endmodule

bind sliding_window_mean_filter swmf_props u_chk (.*);

@@ sim/swmf_checker.sv @@
// Watches the sample, result and size-write channels of the moving average
// filter, keeps its own copy of the window and compares every result beat.
module swmf_checker import swmf_pkg::*; #(
	parameter int WINDOW_MAX = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_stall,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic                       out_valid,
	input  logic                       out_stall,
	input  logic signed [SAMPLE_W-1:0] mean,
	input  logic                       window_full,
	input  logic                       cfg_valid,
	input  logic                       cfg_ready,
	input  logic        [SIZE_W-1:0]   window_size,
	output int                         mismatches,
	output int                         outstanding
);

	typedef struct packed {
		logic [SAMPLE_W-1:0] avg;
		logic                full;
	} avg_result_t;

	logic signed [SAMPLE_W-1:0] window_copy [WINDOW_MAX];
	logic        [SIZE_W-1:0]   size_copy;
	int                         head_pos;
	bit                         wrapped;
	int                         window_sum;
	int                         fail_count = 0;
	avg_result_t                avg_q [$];

	// size 0 behaves as 1, anything past the store depth as the full store
	function automatic int span();
		if (size_copy == '0)
			return 1;
		if (int'(size_copy) > WINDOW_MAX)
			return WINDOW_MAX;
		return int'(size_copy);
	endfunction

	task automatic clear_window();
		foreach (window_copy[i])
			window_copy[i] = '0;
		head_pos   = 0;
		wrapped    = 1'b0;
		window_sum = 0;
	endtask

	task automatic take_sample(input logic signed [SAMPLE_W-1:0] s);
		int          len;
		int          pos;
		avg_result_t r;
		len = span();
		pos = (head_pos >= len) ? 0 : head_pos;
		window_sum += int'(s) - int'(window_copy[pos]);
		window_copy[pos] = s;
		pos++;
		if (pos >= len) begin
			pos     = 0;
			wrapped = 1'b1;
		end
		head_pos = pos;
		r.full = wrapped;
		// int division truncates toward zero
		r.avg  = wrapped ? SAMPLE_W'(window_sum / len) : '0;
		avg_q.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		avg_result_t want;
		if (!arst_n) begin
			size_copy = SIZE_RESET;
			clear_window();
			avg_q.delete();
			outstanding <= 0;
			mismatches  <= fail_count;
		end else begin
			if (cfg_valid && cfg_ready) begin
				size_copy = window_size;
				clear_window();
			end
			if (in_valid && !in_stall)
				take_sample(sample);
			if (out_valid && !out_stall) begin
				if (avg_q.size() == 0) begin
					$display("%0t: result beat with none pending: mean %0d full %0b",
						$time, mean, window_full);
					fail_count++;
				end else begin
					want = avg_q.pop_front();
					if (mean !== want.avg) begin
						$display("%0t: mean expected %0d actual %0d",
							$time, $signed(want.avg), mean);
						fail_count++;
					end
					if (window_full !== want.full) begin
						$display("%0t: window_full expected %0b actual %0b",
							$time, want.full, window_full);
						fail_count++;
					end
				end
			end
			outstanding <= avg_q.size();
			mismatches  <= fail_count;
		end
	end

endmodule

@@ sim/sliding_window_mean_filter_tb.sv @@
// Top of the moving average filter bench: clock, reset, sample and size-write
// stimulus, result back-pressure, watchdog and verdict. All prediction and
// comparison lives in swmf_checker.
module sliding_window_mean_filter_tb;
	import swmf_pkg::*;

	localparam int WINDOW_MAX    = 32;
	localparam int ITEM_TARGET   = 1700;
	// a result shows once its sample's divide is done, leave some margin
	localparam int SETTLE_CYCLES = 40;
	// worst beat-to-beat spacing is latency plus a long gap plus a long stall;
	// this limit is many times that
	localparam int IDLE_LIMIT    = 3000;

	localparam logic signed [SAMPLE_W-1:0] RAIL_HIGH = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam logic signed [SAMPLE_W-1:0] RAIL_LOW  = {1'b1, {(SAMPLE_W-1){1'b0}}};

	// sample flavor of one phase
	typedef enum int {
		MIX_UNIFORM,
		MIX_RAIL_HIGH,
		MIX_RAIL_LOW,
		MIX_NEAR_ZERO,
		MIX_SWING
	} mix_t;

	logic                       clk;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_stall;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       out_valid;
	logic                       out_stall;
	logic signed [SAMPLE_W-1:0] mean;
	logic                       window_full;
	logic                       cfg_valid;
	logic                       cfg_ready;
	logic        [SIZE_W-1:0]   window_size;

	int mismatch_total;
	int results_owed;
	int quiet_cycles;
	int samples_sent;
	bit calm;  // phase with no gaps and no stalls

	sliding_window_mean_filter #(
		.WINDOW_MAX (WINDOW_MAX)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.sample      (sample),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.mean        (mean),
		.window_full (window_full),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.window_size (window_size)
	);

	swmf_checker #(
		.WINDOW_MAX (WINDOW_MAX)
	) i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.sample      (sample),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.mean        (mean),
		.window_full (window_full),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.window_size (window_size),
		.mismatches  (mismatch_total),
		.outstanding (results_owed)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Gap length shared by the sender and the result stall:
	// mostly none or short, now and then a long one.
	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] draw_sample(input mix_t mix);
		case (mix)
			MIX_RAIL_HIGH: return RAIL_HIGH;
			MIX_RAIL_LOW:  return RAIL_LOW;
			MIX_SWING:     return $urandom_range(0, 1) ? RAIL_HIGH : RAIL_LOW;
			// -4 .. +4, wraps to negative through the 16-bit subtract
			MIX_NEAR_ZERO: return SAMPLE_W'($urandom_range(0, 8)) - SAMPLE_W'(4);
			default:       return SAMPLE_W'($urandom);
		endcase
	endfunction

	// Offer one sample beat and return at the edge that takes it.
	// in_valid stays high on return so a back-to-back beat needs no toggle.
	task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample   <= s;
		do @(posedge clk); while (in_stall !== 1'b0);
		samples_sent++;
	endtask

	// Drop the sample channel and wait until every result has come back.
	// The count is read only after an edge, since the checker registers it.
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (results_owed != 0);
	endtask

	// Size write only with the filter idle; it also clears the window.
	task automatic write_window_size(input logic [SIZE_W-1:0] v);
		drain();
		cfg_valid   <= 1'b1;
		window_size <= v;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
	endtask

	// Opening phases: both size extremes, the zero and oversize cases, and sizes
	// near the store depth; the rail flavors drive the sum to its limits.
	task automatic opening_phase(input int k, output logic [SIZE_W-1:0] sz,
			output mix_t mix);
		case (k)
			0:       begin sz = 6'd0;  mix = MIX_UNIFORM;   end
			1:       begin sz = 6'd1;  mix = MIX_SWING;     end
			2:       begin sz = 6'd32; mix = MIX_RAIL_HIGH; end
			3:       begin sz = 6'd63; mix = MIX_RAIL_LOW;  end
			4:       begin sz = 6'd2;  mix = MIX_NEAR_ZERO; end
			5:       begin sz = 6'd33; mix = MIX_UNIFORM;   end
			6:       begin sz = 6'd31; mix = MIX_SWING;     end
			default: begin sz = SIZE_RESET; mix = MIX_UNIFORM; end
		endcase
	endtask

	// Result back-pressure: random stall bursts with quiet stretches between.
	initial begin : stall_gen
		int hold;
		@(posedge clk);
		forever begin
			hold = pick_gap();
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	// Watchdog: counts edges at which no channel moves a beat.
	always @(posedge clk) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("** sliding_window_mean_filter: FAILED **");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int                phase;
		int                r;
		int                count;
		logic [SIZE_W-1:0] sz;
		mix_t              mix;

		arst_n       = 1'b0;
		in_valid     = 1'b0;
		sample       = '0;
		out_stall    = 1'b0;
		cfg_valid    = 1'b0;
		window_size  = '0;
		calm         = 1'b0;
		samples_sent = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, at the reset size of 20: both rails, zero and +-1 first,
		// then a run that fills the window exactly at beat 20 and a few
		// beats past the wrap.
		send_sample(RAIL_LOW);
		send_sample(RAIL_HIGH);
		send_sample('0);
		send_sample(-16'sd1);
		send_sample(16'sd1);
		repeat (15) send_sample(RAIL_HIGH);
		repeat (3) send_sample(RAIL_LOW);

		// Random phases, each opened by a size write that also clears the
		// window; the first few walk through the size corner cases.
		phase = 0;
		while (samples_sent < ITEM_TARGET) begin
			if (phase < 8) begin
				opening_phase(phase, sz, mix);
			end else begin
				sz = SIZE_W'($urandom_range(0, 63));
				r  = $urandom_range(0, 9);
				mix = (r < 6) ? MIX_UNIFORM :
				      (r == 6) ? MIX_RAIL_HIGH :
				      (r == 7) ? MIX_RAIL_LOW :
				      (r == 8) ? MIX_NEAR_ZERO : MIX_SWING;
			end
			write_window_size(sz);
			calm  = ($urandom_range(0, 4) == 0);
			count = $urandom_range(40, 110);
			repeat (count) send_sample(draw_sample(mix));
			phase++;
		end
		calm = 1'b0;

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_total == 0 && results_owed == 0) begin
			$display("** sliding_window_mean_filter: PASSED **");
		end else begin
			$display("** sliding_window_mean_filter: FAILED **");
		end
		$finish;
	end

endmodule
